/* rtl/rast_pkg.sv */
// Shared constants and types for the range-assign range-sum tree.
package rast_pkg;

  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned IDX_W      = 11;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned SUM_W      = 42;
  localparam int unsigned POS_W      = IDX_W + 1;
  localparam int unsigned LEAVES_DEF = 1024;

  typedef enum logic [TYPE_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ASSIGN = 2'd1,
    REQ_QUERY  = 2'd2
  } req_kind_e;

  typedef struct packed {
    logic             walk;
    logic             assign_op;
    logic [POS_W-1:0] left_pos;
    logic [POS_W-1:0] right_pos;
    logic [VAL_W-1:0] value;
  } walk_cmd_t;

  typedef struct packed {
    logic             ready;
    logic             done;
    logic [SUM_W-1:0] sum;
  } walk_sts_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [VAL_W-1:0] pval;
    logic             flag;
  } node_t;

endpackage

/* rtl/rast_req_if.sv */
// Request channel of the range-assign range-sum tree.
interface rast_req_if;
  logic                             valid;
  logic                             ready;
  logic [rast_pkg::TYPE_W-1:0]      req_type;
  logic [rast_pkg::IDX_W-1:0]       left_index;
  logic [rast_pkg::IDX_W-1:0]       right_index;
  logic signed [rast_pkg::VAL_W-1:0] value;

  modport source (output valid, req_type, left_index, right_index, value, input ready);
  modport sink   (input valid, req_type, left_index, right_index, value, output ready);
endinterface

/* rtl/rast_rsp_if.sv */
// Response channel of the range-assign range-sum tree.
interface rast_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [rast_pkg::SUM_W-1:0] range_sum;
  logic                              is_answer;

  modport source (output valid, range_sum, is_answer, input ready);
  modport sink   (input valid, range_sum, is_answer, output ready);
endinterface

/* rtl/rast_walk.sv */
// Node store and sequencer that walks the lazy segment tree for one request.
module rast_walk #(
  parameter int unsigned LEAVES = rast_pkg::LEAVES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  rast_pkg::walk_cmd_t cmd_i,
  input  logic                done_ready_i,
  output rast_pkg::walk_sts_t sts_o
);

  localparam int unsigned SPAN_LG = $clog2(LEAVES);
  localparam int unsigned NODES   = 2 ** (SPAN_LG + 1);
  localparam int unsigned ADDR_W  = SPAN_LG + 1;
  localparam int unsigned TPOS_W  = SPAN_LG + 1;
  localparam int unsigned LVL_W   = $clog2(SPAN_LG + 1);
  localparam int unsigned SUM_W   = rast_pkg::SUM_W;
  localparam int unsigned VAL_W   = rast_pkg::VAL_W;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_READ  = 10'b0000000100,
    S_EVAL  = 10'b0000001000,
    S_PUSHL = 10'b0000010000,
    S_PUSHR = 10'b0000100000,
    S_RET   = 10'b0001000000,
    S_RDL   = 10'b0010000000,
    S_RDR   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e              state_q, state_d;
  rast_pkg::walk_cmd_t cmd_q, cmd_d;
  logic [ADDR_W-1:0]   node_q, node_d;
  logic [TPOS_W-1:0]   lo_q, lo_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [SUM_W-1:0]    acc_q, acc_d;
  logic [SUM_W-1:0]    left_q, left_d;
  logic [VAL_W-1:0]    pv_q, pv_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;

  rast_pkg::node_t     mem [NODES];
  rast_pkg::node_t     rd_q;
  rast_pkg::node_t     wd;
  logic [ADDR_W-1:0]   rd_addr, wa;
  logic                we;

  logic [LVL_W-1:0]    sh;
  logic [TPOS_W-1:0]   len;
  logic [31:0]         lo32, hi32, l32, r32;
  logic                disj, cont;
  logic [SUM_W-1:0]    v_ext, pv_ext;

  assign sh     = LVL_W'(SPAN_LG) - lvl_q;
  assign len    = TPOS_W'(1) << sh;
  assign lo32   = 32'(lo_q);
  assign hi32   = 32'(lo_q) + 32'(len);
  assign l32    = 32'(cmd_q.left_pos);
  assign r32    = 32'(cmd_q.right_pos);
  assign disj   = (lo32 >= r32) || (hi32 <= l32);
  assign cont   = (lo32 >= l32) && (hi32 <= r32);
  assign v_ext  = {{(SUM_W - VAL_W){cmd_q.value[VAL_W-1]}}, cmd_q.value};
  assign pv_ext = {{(SUM_W - VAL_W){pv_q[VAL_W-1]}}, pv_q};

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    node_d  = node_q;
    lo_d    = lo_q;
    lvl_d   = lvl_q;
    acc_d   = acc_q;
    left_d  = left_q;
    pv_d    = pv_q;
    clr_d   = clr_q;
    rd_addr = node_q;
    we      = 1'b0;
    wa      = node_q;
    wd      = '0;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_i;
          acc_d   = '0;
          node_d  = ADDR_W'(1);
          lo_d    = '0;
          lvl_d   = '0;
          state_d = cmd_i.walk ? S_READ : S_FIN;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (cmd_q.assign_op ? disj : (cont || disj)) begin
          if (!cmd_q.assign_op && cont) begin
            acc_d = acc_q + rd_q.sum;
          end
          state_d = S_RET;
        end else if (cmd_q.assign_op && cont) begin
          we      = 1'b1;
          wd.sum  = v_ext << sh;
          wd.pval = cmd_q.value;
          wd.flag = 1'b1;
          state_d = S_RET;
        end else begin
          node_d = {node_q[ADDR_W-2:0], 1'b0};
          lvl_d  = lvl_q + LVL_W'(1);
          if (rd_q.flag) begin
            we      = 1'b1;
            wd.sum  = rd_q.sum;
            pv_d    = rd_q.pval;
            state_d = S_PUSHL;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_PUSHL: begin
        we      = 1'b1;
        wd.sum  = pv_ext << sh;
        wd.pval = pv_q;
        wd.flag = 1'b1;
        state_d = S_PUSHR;
      end
      S_PUSHR: begin
        we      = 1'b1;
        wa      = node_q | ADDR_W'(1);
        wd.sum  = pv_ext << sh;
        wd.pval = pv_q;
        wd.flag = 1'b1;
        state_d = S_READ;
      end
      S_RET: begin
        if (node_q == ADDR_W'(1)) begin
          state_d = S_FIN;
        end else if (!node_q[0]) begin
          node_d  = node_q + ADDR_W'(1);
          lo_d    = lo_q + len;
          state_d = S_READ;
        end else begin
          node_d = node_q >> 1;
          lo_d   = lo_q - len;
          lvl_d  = lvl_q - LVL_W'(1);
          if (cmd_q.assign_op) begin
            state_d = S_RDL;
          end
        end
      end
      S_RDL: begin
        rd_addr = {node_q[ADDR_W-2:0], 1'b0};
        state_d = S_RDR;
      end
      S_RDR: begin
        rd_addr = {node_q[ADDR_W-2:0], 1'b1};
        left_d  = rd_q.sum;
        state_d = S_RET;
      end
      S_FIN: begin
        if (done_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  rast_pkg::node_t wr_back;
  logic            wp_q;

  assign wr_back = '{sum: left_q + rd_q.sum, pval: '0, flag: 1'b0};

  always_ff @(posedge clk_i) begin
    if (wp_q) begin
      mem[node_q] <= wr_back;
    end else if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      wp_q    <= 1'b0;
    end else begin
      wp_q    <= (state_q == S_RDR);
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    node_q <= node_d;
    lo_q   <= lo_d;
    lvl_q  <= lvl_d;
    acc_q  <= acc_d;
    left_q <= left_d;
    pv_q   <= pv_d;
  end

  assign sts_o.ready = (state_q == S_IDLE);
  assign sts_o.done  = (state_q == S_FIN);
  assign sts_o.sum   = acc_q;

`ifndef NO_ASSERTIONS
  a_leaf_no_descend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && !disj && !cont) |-> (lvl_q != LVL_W'(SPAN_LG)))
    else $error("descent below a leaf");
  a_root_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RET && node_q == ADDR_W'(1)) |=> (state_q == S_FIN))
    else $error("return from root did not finish");
  a_node_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (node_q != '0))
    else $error("read of node zero");
`endif

endmodule

/* rtl/range_assign_range_sum_tree.sv */
// Top level of the range-assign range-sum lazy segment tree.
//
//  channel  direction  payload
//  req_i    in         req_type, left_index, right_index, value
//  rsp_o    out        range_sum, is_answer
//
// After reset a clearing pass writes every node, 2 * 2^ceil(log2(LEAVES)) of them
// (2048 at 1024 leaves), during which no request is taken.
// A request passes each visited node through S_READ, S_EVAL and S_RET; where a pending value
// is pushed down it also writes both children (S_PUSHL, S_PUSHR), and where an assign rebuilds
// a parent sum it reads both children through the single read port of the node store (S_RDL, S_RDR).
// An empty range or an unknown type skips the walk and goes straight to the response.
// A finished response waits in the output register while the next request runs.
module range_assign_range_sum_tree #(
  parameter int unsigned LEAVES = rast_pkg::LEAVES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rast_req_if.sink    req_i,
  rast_rsp_if.source  rsp_o
);

  localparam int unsigned POS_W = rast_pkg::POS_W;

  rast_pkg::walk_cmd_t cmd;
  rast_pkg::walk_sts_t sts;
  logic                start, done_ready;
  logic [31:0]         l32, r32, lc32, rc32;
  logic                ans_q;
  logic                out_valid_q;
  logic [rast_pkg::SUM_W-1:0] out_sum_q;
  logic                out_ans_q;

  assign l32  = 32'(req_i.left_index);
  assign r32  = 32'(req_i.right_index);
  assign lc32 = (l32 > 32'(LEAVES)) ? 32'(LEAVES) : l32;
  assign rc32 = (r32 > 32'(LEAVES)) ? 32'(LEAVES) : r32;

  always_comb begin
    cmd           = '0;
    cmd.value     = req_i.value;
    cmd.left_pos  = lc32[POS_W-1:0];
    cmd.right_pos = rc32[POS_W-1:0];
    unique case (rast_pkg::req_kind_e'(req_i.req_type))
      rast_pkg::REQ_LOAD: begin
        cmd.walk      = (lc32 < 32'(LEAVES));
        cmd.assign_op = 1'b1;
        cmd.right_pos = lc32[POS_W-1:0] + POS_W'(1);
      end
      rast_pkg::REQ_ASSIGN: begin
        cmd.walk      = (lc32 < rc32);
        cmd.assign_op = 1'b1;
      end
      rast_pkg::REQ_QUERY: begin
        cmd.walk = (lc32 < rc32);
      end
      default: begin
        cmd.walk = 1'b0;
      end
    endcase
  end

  assign req_i.ready = sts.ready;
  assign start       = req_i.valid && sts.ready;
  assign done_ready  = !out_valid_q || rsp_o.ready;

  rast_walk #(
    .LEAVES(LEAVES)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd),
    .done_ready_i(done_ready),
    .sts_o       (sts)
  );

  always_ff @(posedge clk_i) begin
    if (start) begin
      ans_q <= (req_i.req_type == rast_pkg::REQ_QUERY);
    end
    if (sts.done && done_ready) begin
      out_sum_q <= sts.sum;
      out_ans_q <= ans_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sts.done && done_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.range_sum = out_sum_q;
  assign rsp_o.is_answer = out_ans_q;

endmodule
